/* rtl/asl_pkg.sv */
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types and constants of the actuator safety limiter.
// ----------------------------------------------------------------------------
package asl_pkg;

  localparam int ValW     = 32;
  localparam int RateW    = 31;
  localparam int ChanW    = 6;
  localparam int MissW    = 8;
  localparam int OpW      = 2;
  localparam int LevelW   = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEGRADE_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAFE_LIMIT    = 1'd1;

  localparam logic [CfgDataW-1:0] DegradeLimitRst = 8'd5;
  localparam logic [CfgDataW-1:0] SafeLimitRst    = 8'd10;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_CONFIG  = 2'd0,
    OP_COMMAND = 2'd1,
    OP_ESTOP   = 2'd2,
    OP_UPDATE  = 2'd3
  } op_e;

  typedef enum logic [LevelW-1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_DEGRADED = 2'd1,
    MODE_SAFE     = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // per-channel profile, one memory word
  typedef struct packed {
    logic signed [ValW-1:0] safe_val;
    logic signed [ValW-1:0] lo_lim;
    logic signed [ValW-1:0] hi_lim;
    logic [RateW-1:0]       rate;
  } prof_t;

endpackage

/* rtl/asl_if.sv */
// ----------------------------------------------------------------------------
// asl_if
// Valid/ready channels of the limiter: item in, result out.
// ----------------------------------------------------------------------------
interface asl_in_if;
  logic                              valid;
  logic                              ready;
  logic [asl_pkg::OpW-1:0]           op;
  logic [asl_pkg::ChanW-1:0]         channel;
  logic signed [asl_pkg::ValW-1:0]   value;
  logic signed [asl_pkg::ValW-1:0]   low_limit;
  logic signed [asl_pkg::ValW-1:0]   high_limit;
  logic [asl_pkg::RateW-1:0]         rate_limit;
  logic [asl_pkg::MissW-1:0]         miss_count;

  modport source (output valid, op, channel, value, low_limit, high_limit, rate_limit,
                  miss_count, input ready);
  modport sink   (input valid, op, channel, value, low_limit, high_limit, rate_limit,
                  miss_count, output ready);
endinterface

interface asl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [asl_pkg::ValW-1:0]   out_value;
  logic [asl_pkg::ChanW-1:0]         out_channel;
  logic [asl_pkg::LevelW-1:0]        safety_level;
  logic                              status;

  modport source (output valid, out_value, out_channel, safety_level, status, input ready);
  modport sink   (input valid, out_value, out_channel, safety_level, status, output ready);
endinterface

/* rtl/asl_ram.sv */
// ----------------------------------------------------------------------------
// asl_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module asl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/actuator_safety_limiter.sv */
// ----------------------------------------------------------------------------
// actuator_safety_limiter
// Per-channel slew limit and clamp of actuator commands, with estop latch
// and a heartbeat-driven safety level.
// ----------------------------------------------------------------------------
//  port      dir  kind          carries
//  req_i     in   valid/ready   op, channel, value, limits, rate, miss count
//  rsp_o     out  valid/ready   out_value, out_channel, safety_level, status
//  cfg_*_i   in   write only    degrade / safe miss limits
//
//  The accept edge reads the profile and last-output RAMs, the next cycle does
//  the slew step, the one after clamps, writes back and loads the result
//  register. The next item is accepted on that write-back edge; forward
//  registers cover the overlap. No clearing pass after reset: channel
//  enables are flops.
//  A stalled result holds the clamp stage and blocks the input.
// ----------------------------------------------------------------------------
module actuator_safety_limiter #(
  parameter int CHANNELS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  asl_in_if.sink                             req_i,
  asl_out_if.source                          rsp_o,
  input  logic                               cfg_we_i,
  input  logic [asl_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [asl_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  localparam int AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ExtW  = asl_pkg::ValW + 2;

  // configuration
  logic [asl_pkg::CfgDataW-1:0] degrade_lim_q, safe_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degrade_lim_q <= asl_pkg::DegradeLimitRst;
      safe_lim_q    <= asl_pkg::SafeLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asl_pkg::CFG_DEGRADE_LIMIT: degrade_lim_q <= cfg_wdata_i;
        asl_pkg::CFG_SAFE_LIMIT:    safe_lim_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control
  asl_pkg::state_e state_q, state_d;
  logic            out_valid_q;
  logic            out_free, done_fire, in_acc;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign done_fire   = (state_q == asl_pkg::ST_DONE) && out_free;
  assign req_i.ready = (state_q == asl_pkg::ST_IDLE) || done_fire;
  assign in_acc      = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      asl_pkg::ST_IDLE: if (in_acc) state_d = asl_pkg::ST_READ;
      asl_pkg::ST_READ: state_d = asl_pkg::ST_DONE;
      asl_pkg::ST_DONE: begin
        if (done_fire) state_d = in_acc ? asl_pkg::ST_READ : asl_pkg::ST_IDLE;
      end
      default: state_d = asl_pkg::ST_IDLE;
    endcase
  end

  // item registers
  asl_pkg::op_e                     op_q;
  logic [asl_pkg::ChanW-1:0]        ch_q;
  logic signed [asl_pkg::ValW-1:0]  val_q, lo_q, hi_q;
  logic [asl_pkg::RateW-1:0]        rate_q;
  logic [asl_pkg::MissW-1:0]        miss_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= asl_pkg::op_e'(req_i.op);
      ch_q   <= req_i.channel;
      val_q  <= req_i.value;
      lo_q   <= req_i.low_limit;
      hi_q   <= req_i.high_limit;
      rate_q <= req_i.rate_limit;
      miss_q <= req_i.miss_count;
    end
  end

  logic [AddrW-1:0] req_addr, item_addr;
  logic             ch_ok;

  assign req_addr  = AddrW'(req_i.channel);
  assign item_addr = AddrW'(ch_q);
  assign ch_ok     = int'(ch_q) < CHANNELS;

  // memories
  asl_pkg::prof_t                  prof_rd, prof_wr, prof_cur;
  logic signed [asl_pkg::ValW-1:0] last_rd, last_wr, prev;
  logic                            prof_we, last_we;

  assign prof_wr = '{safe_val: val_q, lo_lim: lo_q, hi_lim: hi_q, rate: rate_q};

  asl_ram #(.Width($bits(asl_pkg::prof_t)), .Depth(CHANNELS)) u_prof_ram (
    .clk_i  (clk_i),
    .we_i   (prof_we),
    .waddr_i(item_addr),
    .wdata_i(prof_wr),
    .re_i   (in_acc),
    .raddr_i(req_addr),
    .rdata_o(prof_rd)
  );

  asl_ram #(.Width(asl_pkg::ValW), .Depth(CHANNELS)) u_last_ram (
    .clk_i  (clk_i),
    .we_i   (last_we),
    .waddr_i(item_addr),
    .wdata_i(last_wr),
    .re_i   (in_acc),
    .raddr_i(req_addr),
    .rdata_o(last_rd)
  );

  // forwarding of the most recent write per memory
  logic                            pf_vld_q, lf_vld_q;
  logic [AddrW-1:0]                pf_addr_q, lf_addr_q;
  asl_pkg::prof_t                  pf_data_q;
  logic signed [asl_pkg::ValW-1:0] lf_data_q;

  always_ff @(posedge clk_i) begin
    if (prof_we) begin
      pf_addr_q <= item_addr;
      pf_data_q <= prof_wr;
    end
    if (last_we) begin
      lf_addr_q <= item_addr;
      lf_data_q <= last_wr;
    end
  end

  assign prof_cur = (pf_vld_q && pf_addr_q == item_addr) ? pf_data_q : prof_rd;
  assign prev     = (lf_vld_q && lf_addr_q == item_addr) ? lf_data_q : last_rd;

  // slew step
  logic signed [ExtW-1:0] cmd_x, prev_x, rate_x, hi_step, lo_step;
  logic                   rate_on, rate_full, step_up, step_dn;
  logic signed [asl_pkg::ValW-1:0] slew_v;

  assign cmd_x     = ExtW'(val_q);
  assign prev_x    = ExtW'(prev);
  assign rate_x    = ExtW'(prof_cur.rate);
  assign hi_step   = prev_x + rate_x;
  assign lo_step   = prev_x - rate_x;
  assign rate_on   = prof_cur.rate != '0;
  // at the largest rate a saturated upward difference never exceeds it
  assign rate_full = &prof_cur.rate;
  assign step_up   = rate_on && !rate_full && (cmd_x > hi_step);
  assign step_dn   = rate_on && (cmd_x < lo_step);
  assign slew_v    = step_up ? hi_step[asl_pkg::ValW-1:0] :
                     step_dn ? lo_step[asl_pkg::ValW-1:0] : val_q;

  logic signed [asl_pkg::ValW-1:0] slew_q, safe_q, min_q, max_q;
  logic                            inv_q;

  always_ff @(posedge clk_i) begin
    if (state_q == asl_pkg::ST_READ) begin
      slew_q <= slew_v;
      safe_q <= prof_cur.safe_val;
      min_q  <= prof_cur.lo_lim;
      max_q  <= prof_cur.hi_lim;
      inv_q  <= prof_cur.lo_lim > prof_cur.hi_lim;
    end
  end

  // clamp, max wins when the bounds cross
  logic                            gt_max, lt_min;
  logic signed [asl_pkg::ValW-1:0] clamp_v, cmd_v;

  assign gt_max  = slew_q > max_q;
  assign lt_min  = slew_q < min_q;
  assign clamp_v = (gt_max || (lt_min && inv_q)) ? max_q : (lt_min ? min_q : slew_q);

  // safety state and result
  logic                            estop_q, estop_d;
  asl_pkg::mode_e                  mode_q, mode_d;
  logic [CHANNELS-1:0]             active_q;
  logic                            cmd_live;
  logic signed [asl_pkg::ValW-1:0] res_value;
  logic [asl_pkg::ChanW-1:0]       res_chan;
  logic                            res_status;

  assign cmd_v    = (estop_q || mode_q != asl_pkg::MODE_NORMAL) ? safe_q : clamp_v;
  assign cmd_live = ch_ok && active_q[item_addr];

  always_comb begin
    res_value  = '0;
    res_chan   = '0;
    res_status = asl_pkg::STATUS_DONE;
    estop_d    = estop_q;
    mode_d     = mode_q;
    case (op_q)
      asl_pkg::OP_CONFIG: begin
        res_chan = ch_q;
        if (!ch_ok) res_status = asl_pkg::STATUS_IGNORED;
        else        res_value  = val_q;
      end
      asl_pkg::OP_COMMAND: begin
        res_chan = ch_q;
        if (!cmd_live) res_status = asl_pkg::STATUS_IGNORED;
        else           res_value  = cmd_v;
      end
      asl_pkg::OP_ESTOP: estop_d = 1'b1;
      asl_pkg::OP_UPDATE: begin
        if (estop_q && mode_q != asl_pkg::MODE_SAFE) begin
          mode_d = asl_pkg::MODE_SAFE;
        end else begin
          case (mode_q)
            asl_pkg::MODE_NORMAL: begin
              if (miss_q >= degrade_lim_q) mode_d = asl_pkg::MODE_DEGRADED;
            end
            asl_pkg::MODE_DEGRADED: begin
              if (miss_q >= safe_lim_q) mode_d = asl_pkg::MODE_SAFE;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign prof_we = done_fire && ch_ok && (op_q == asl_pkg::OP_CONFIG);
  assign last_we = done_fire && ((op_q == asl_pkg::OP_CONFIG && ch_ok) ||
                                 (op_q == asl_pkg::OP_COMMAND && cmd_live));
  assign last_wr = (op_q == asl_pkg::OP_CONFIG) ? val_q : cmd_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      estop_q     <= 1'b0;
      mode_q      <= asl_pkg::MODE_NORMAL;
      active_q    <= '0;
      pf_vld_q    <= 1'b0;
      lf_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_fire) begin
        out_valid_q <= 1'b1;
        estop_q     <= estop_d;
        mode_q      <= mode_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (prof_we) begin
        active_q[item_addr] <= 1'b1;
        pf_vld_q            <= 1'b1;
      end
      if (last_we) lf_vld_q <= 1'b1;
    end
  end

  // output register
  logic signed [asl_pkg::ValW-1:0] out_value_q;
  logic [asl_pkg::ChanW-1:0]       out_chan_q;
  logic [asl_pkg::LevelW-1:0]      out_level_q;
  logic                            out_status_q;

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_value_q  <= res_value;
      out_chan_q   <= res_chan;
      out_level_q  <= mode_d;
      out_status_q <= res_status;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.out_value    = out_value_q;
  assign rsp_o.out_channel  = out_chan_q;
  assign rsp_o.safety_level = out_level_q;
  assign rsp_o.status       = out_status_q;

endmodule

/* rtl/asl_checker.sv */
// ----------------------------------------------------------------------------
// asl_assertions
// Port-level checks on the limiter, bound to the top level.
// ----------------------------------------------------------------------------
module asl_assertions (
  input  logic        clk_i,
  input  logic        rst_ni,
  asl_in_if.sink      req_i,
  asl_out_if.source   rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> $stable(rsp_o.out_value) &&
      $stable(rsp_o.out_channel) && $stable(rsp_o.safety_level) && $stable(rsp_o.status))
    else $error("stalled result changed");

  // one item in flight: the cycle after an accept is always busy
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("input accepted on consecutive cycles");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status |-> rsp_o.out_value == '0)
    else $error("ignored transaction carries a value");

endmodule

bind actuator_safety_limiter asl_assertions u_asl_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req_i (req_i),
  .rsp_o (rsp_o)
);

/* dv/asl_checker.sv */
// ----------------------------------------------------------------------------
// asl_checker
// Watches the limiter's item and result channels and its register port. It
// predicts each result from its own copy of the channel tables and safety
// state, then compares the results in order, field by field.
// ----------------------------------------------------------------------------
module asl_checker
  import asl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  asl_in_if                   req_i,
  asl_out_if                  rsp_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  mismatches_o,
  output int                  outstanding_o,
  output int                  checked_o
);

  localparam int     NumChan = 64;
  localparam longint I32Max  = 64'sh7FFF_FFFF;
  localparam longint I32Min  = -64'sh8000_0000;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [ChanW-1:0]       chan;
    logic [LevelW-1:0]      level;
    logic                   status;
  } outcome_t;

  int             safe_val [NumChan];
  int             lo_lim   [NumChan];
  int             hi_lim   [NumChan];
  int             step_max [NumChan];
  int             last_out [NumChan];
  bit             active   [NumChan];
  bit             estop_set;
  mode_e          mode;
  logic [MissW-1:0] degrade_lim;
  logic [MissW-1:0] safe_lim;
  outcome_t       pending_outputs [$];

  // slew step against the previous output, then min clamp, then max clamp
  function automatic int slew_clamp(int ch, int cmd);
    longint prev;
    longint step;
    longint v;
    longint d;
    prev = last_out[ch];
    step = step_max[ch];
    v    = cmd;
    if (step > 0) begin
      d = v - prev;
      if (d > I32Max) d = I32Max;
      if (d < I32Min) d = I32Min;
      if ((d < 0 ? -d : d) > step) v = (d >= 0) ? prev + step : prev - step;
    end
    if (v < lo_lim[ch]) v = lo_lim[ch];
    if (v > hi_lim[ch]) v = hi_lim[ch];
    return int'(v);
  endfunction

  function automatic outcome_t apply_item(op_e op, logic [ChanW-1:0] ch,
                                          logic signed [ValW-1:0] val,
                                          logic signed [ValW-1:0] lo,
                                          logic signed [ValW-1:0] hi,
                                          logic [RateW-1:0] rate,
                                          logic [MissW-1:0] miss);
    outcome_t o;
    int       idx;
    o   = '0;
    idx = int'(ch);
    case (op)
      OP_CONFIG: begin
        o.chan        = ch;
        safe_val[idx] = val;
        lo_lim[idx]   = lo;
        hi_lim[idx]   = hi;
        step_max[idx] = int'({1'b0, rate});
        last_out[idx] = val;
        active[idx]   = 1'b1;
        o.value       = val;
      end
      OP_COMMAND: begin
        o.chan = ch;
        if (!active[idx]) begin
          o.status = STATUS_IGNORED;
        end else begin
          if (estop_set || mode != MODE_NORMAL) o.value = safe_val[idx];
          else o.value = slew_clamp(idx, val);
          last_out[idx] = o.value;
        end
      end
      OP_ESTOP: begin
        estop_set = 1'b1;
      end
      default: begin
        // one level step per update at most; the latch skips straight to safe
        if (estop_set && mode != MODE_SAFE) mode = MODE_SAFE;
        else if (mode == MODE_NORMAL && miss >= degrade_lim) mode = MODE_DEGRADED;
        else if (mode == MODE_DEGRADED && miss >= safe_lim) mode = MODE_SAFE;
      end
    endcase
    o.level = mode;
    return o;
  endfunction

  always @(posedge clk_i) begin : monitor
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) active[i] = 1'b0;
      estop_set    = 1'b0;
      mode         = MODE_NORMAL;
      degrade_lim  = DegradeLimitRst;
      safe_lim     = SafeLimitRst;
      mismatches_o = 0;
      checked_o    = 0;
      pending_outputs.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEGRADE_LIMIT: degrade_lim = cfg_wdata_i;
          CFG_SAFE_LIMIT:    safe_lim    = cfg_wdata_i;
          default: ;
        endcase
      end
      // results first: a result never belongs to an item accepted on this edge
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.out_value, rsp_i.out_channel, rsp_i.safety_level, rsp_i.status};
        if (pending_outputs.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("ERROR: unexpected result value=%0d ch=%0d level=%0d status=%0d",
                     got.value, got.chan, got.level, got.status);
        end else begin
          want = pending_outputs.pop_front();
          checked_o++;
          if (got.value !== want.value || got.chan !== want.chan ||
              got.level !== want.level || got.status !== want.status) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display({"ERROR: result %0d: expected value=%0d ch=%0d level=%0d status=%0d,",
                        " got value=%0d ch=%0d level=%0d status=%0d"},
                       checked_o, want.value, want.chan, want.level, want.status,
                       got.value, got.chan, got.level, got.status);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        pending_outputs.push_back(apply_item(op_e'(req_i.op), req_i.channel, req_i.value,
                                             req_i.low_limit, req_i.high_limit,
                                             req_i.rate_limit, req_i.miss_count));
    end
    outstanding_o = pending_outputs.size();
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the actuator safety limiter with directed corner items and random
// traffic while walking the safety level from normal through degraded to
// safe, under three handshake idle profiles; asl_checker scores the results.
// ----------------------------------------------------------------------------
module testbench;
  import asl_pkg::*;

  localparam int StallLimit = 2000;
  localparam logic signed [ValW-1:0] ValMax  = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin  = 32'sh8000_0000;
  localparam logic [RateW-1:0]       RateMax = '1;

  typedef struct {
    op_e                    op;
    logic [ChanW-1:0]       chan;
    logic signed [ValW-1:0] value;
    logic signed [ValW-1:0] lo;
    logic signed [ValW-1:0] hi;
    logic [RateW-1:0]       rate;
    logic [MissW-1:0]       miss;
  } item_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  src_idle_pct;
  int                  sink_idle_pct;
  int                  items_sent;
  int                  idle_cycles;
  int                  mismatches;
  int                  outstanding;
  int                  checked;
  logic [MissW-1:0]    degrade_at;
  logic [MissW-1:0]    safe_at;

  asl_in_if  req_if ();
  asl_out_if rsp_if ();

  actuator_safety_limiter #(.CHANNELS(64)) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  asl_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == StallLimit) begin
      $display("Timeout: no transaction for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic item_t mk(op_e op, logic [ChanW-1:0] ch, logic signed [ValW-1:0] v,
                               logic signed [ValW-1:0] lo, logic signed [ValW-1:0] hi,
                               logic [RateW-1:0] rate, logic [MissW-1:0] miss);
    item_t it;
    it.op    = op;
    it.chan  = ch;
    it.value = v;
    it.lo    = lo;
    it.hi    = hi;
    it.rate  = rate;
    it.miss  = miss;
    return it;
  endfunction

  function automatic logic signed [ValW-1:0] rand_val();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return $urandom;
    if (pick < 50) return $urandom_range(1 << 20) - (1 << 19);
    if (pick < 60) begin
      case ($urandom_range(3))
        0:       return ValMax;
        1:       return ValMin;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom_range(1 << 26) - (1 << 25);
  endfunction

  // mostly a small working set of channels so commands find configured ones
  function automatic logic [ChanW-1:0] pick_chan();
    if ($urandom_range(99) < 75) return ChanW'($urandom_range(15));
    return ChanW'($urandom_range(63));
  endfunction

  function automatic item_t rand_item(int miss_max, bit with_estop);
    item_t                  it;
    int unsigned            pick;
    logic signed [ValW-1:0] a;
    logic signed [ValW-1:0] b;
    it = mk(OP_COMMAND, pick_chan(), rand_val(), $urandom, $urandom, RateW'($urandom),
            MissW'($urandom));
    pick = $urandom_range(99);
    if (pick < 15) begin
      it.op = OP_CONFIG;
      a = rand_val();
      b = rand_val();
      case ($urandom_range(4))
        0, 1, 2: begin
          it.lo = (a < b) ? a : b;
          it.hi = (a < b) ? b : a;
        end
        3: begin
          it.lo = ValMin;
          it.hi = ValMax;
        end
        default: ;  // raw bounds, min may exceed max
      endcase
      case ($urandom_range(4))
        0:       it.rate = '0;
        1:       it.rate = 31'd1;
        2:       it.rate = RateW'($urandom_range(1 << 18, 1));
        3:       it.rate = RateMax;
        default: ;
      endcase
    end else if (pick < 85) begin
      it.op = OP_COMMAND;
    end else if (pick < 97 || !with_estop) begin
      it.op   = OP_UPDATE;
      it.miss = MissW'($urandom_range(miss_max));
    end else begin
      it.op = OP_ESTOP;
    end
    return it;
  endfunction

  task automatic send(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.op         = it.op;
    req_if.channel    = it.chan;
    req_if.value      = it.value;
    req_if.low_limit  = it.lo;
    req_if.high_limit = it.hi;
    req_if.rate_limit = it.rate;
    req_if.miss_count = it.miss;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_random(input int count, input int miss_max, input bit with_estop,
                            input bit with_pause);
    for (int i = 0; i < count; i++) begin
      if (with_pause && i == count / 2) drain();
      send(rand_item(miss_max, with_estop));
    end
  endtask

  initial begin
    req_if.valid      = 1'b0;
    req_if.op         = OP_CONFIG;
    req_if.channel    = '0;
    req_if.value      = '0;
    req_if.low_limit  = '0;
    req_if.high_limit = '0;
    req_if.rate_limit = '0;
    req_if.miss_count = '0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_DEGRADE_LIMIT;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    src_idle_pct      = 32;
    sink_idle_pct     = 69;
    items_sent        = 0;
    degrade_at        = '0;
    safe_at           = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(CFG_DEGRADE_LIMIT, 8'd255);
    write_reg(CFG_SAFE_LIMIT, 8'd0);

    send(mk(OP_COMMAND, 6'd5, 32'sd777, '0, '0, '0, '0));        // never configured
    send(mk(OP_CONFIG, 6'd0, '0, ValMin, ValMax, '0, '0));
    send(mk(OP_COMMAND, 6'd0, ValMax, '0, '0, '0, '0));
    send(mk(OP_COMMAND, 6'd0, ValMin, '0, '0, '0, '0));
    send(mk(OP_CONFIG, 6'd1, ValMin, ValMin, ValMax, 31'd1, '0));
    send(mk(OP_COMMAND, 6'd1, ValMax, '0, '0, '0, '0));           // saturated difference
    send(mk(OP_CONFIG, 6'd2, ValMax, ValMin, ValMax, RateMax, '0));
    send(mk(OP_COMMAND, 6'd2, ValMin, '0, '0, '0, '0));
    send(mk(OP_COMMAND, 6'd2, ValMax, '0, '0, '0, '0));
    send(mk(OP_CONFIG, 6'd3, 32'sd100, ValMin, ValMax, 31'd1, '0));
    send(mk(OP_COMMAND, 6'd3, 32'sd100, '0, '0, '0, '0));         // zero difference
    send(mk(OP_COMMAND, 6'd3, 32'sd99, '0, '0, '0, '0));
    send(mk(OP_CONFIG, 6'd4, '0, 32'sd1000, -32'sd1000, '0, '0)); // min above max
    send(mk(OP_COMMAND, 6'd4, 32'sd5000, '0, '0, '0, '0));
    send(mk(OP_COMMAND, 6'd4, ValMin, '0, '0, '0, '0));
    send(mk(OP_CONFIG, 6'd63, -32'sd65536, -32'sd131072, 32'sd131072, 31'h8000, '0));
    send(mk(OP_COMMAND, 6'd63, 32'sd1048576, '0, '0, '0, '0));
    send(mk(OP_COMMAND, 6'd63, -32'sd1048576, '0, '0, '0, '0));
    send(mk(OP_UPDATE, '0, '0, '0, '0, '0, 8'd254));
    send(mk(OP_UPDATE, '0, '0, '0, '0, '0, 8'd1));

    // normal level throughout; one full stop of the sender mid-burst
    run_random(520, 254, 1'b0, 1'b1);
    drain();

    degrade_at = MissW'($urandom_range(200, 100));
    write_reg(CFG_DEGRADE_LIMIT, degrade_at);
    write_reg(CFG_SAFE_LIMIT, 8'd255);
    src_idle_pct  = 69;
    sink_idle_pct = 32;
    run_random(520, int'(degrade_at) - 1, 1'b0, 1'b0);
    send(mk(OP_UPDATE, '0, '0, '0, '0, '0, degrade_at - 8'd1));
    send(mk(OP_UPDATE, '0, '0, '0, '0, '0, degrade_at));           // normal -> degraded
    send(mk(OP_COMMAND, 6'd0, ValMax, '0, '0, '0, '0));
    drain();

    safe_at = MissW'($urandom_range(250, 50));
    write_reg(CFG_SAFE_LIMIT, safe_at);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(330, int'(safe_at) - 1, 1'b0, 1'b0);
    send(mk(OP_UPDATE, '0, '0, '0, '0, '0, safe_at - 8'd1));
    send(mk(OP_ESTOP, '0, '0, '0, '0, '0, '0));
    send(mk(OP_COMMAND, 6'd2, 32'sd4242, '0, '0, '0, '0));
    send(mk(OP_UPDATE, '0, '0, '0, '0, '0, '0));                   // latch forces safe
    run_random(150, 255, 1'b1, 1'b0);
    drain();

    $display("Run: %0d transactions sent, %0d results scored across normal, degraded and",
             items_sent, checked);
    $display("     estop-forced safe levels; miss limits degrade 255/%0d, safe 0/255/%0d",
             degrade_at, safe_at);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
